FILE: rtl/tewq_pkg.sv
// Package: shared types, codes and sizes of the thread event wait queue engine.
`timescale 1ns / 1ps
`default_nettype none
package tewq_pkg;
	localparam int THREADS = 64;
	localparam int EVENTS = 256;
	localparam int TW = $clog2(THREADS);
	localparam int EW = $clog2(EVENTS);
	localparam logic [8:0] LATCH_RESET = 9'd240;

	typedef enum logic [2:0] {
		K_NEW = 3'd0, K_WAIT = 3'd1, K_SEND = 3'd2, K_DEQ = 3'd3,
		K_KILL = 3'd4, K_PEEK = 3'd5, K_POLL = 3'd6, K_CLEAR = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NO_THREAD = 3'd1, ST_FULL = 3'd2,
		ST_BUSY = 3'd3, ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		M_PAUSED = 2'd0, M_QUEUED = 2'd1, M_WAITING = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_LINK, S_EXEC, S_WALK, S_WALKRD, S_CLEAR, S_OUT
	} fsm_t;

	// event queue entry: pending flag, valid, front, back
	typedef struct packed {
		logic          pend;
		logic          valid;
		logic [TW-1:0] front;
		logic [TW-1:0] back;
	} evq_t;
endpackage
`default_nettype wire

FILE: rtl/tewq_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tewq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/thread_event_wait_queue_engine_top.sv
// Top level: thread slot allocator, run queue and per-event wait queues.
//
// Usage: one input channel (kind, thread_id, event_id) with in_valid/in_stall
// and one result channel (status, thread_out, woke, pending) with
// out_valid/out_stall. Each input beat gives exactly one result beat.
// Items are processed one at a time; in_stall is high while an item is in work
// or its result waits.
// Flow: an accepted item passes through memory read, execute and the result
// register; a send adds a read of the wait link between read and execute.
// Dequeue of a thread not at the run head walks the run list through the link
// memory, reading each list member in turn, and then relinks the list.
// The event memory (pending flag, front/back per event) has no per-entry
// reset: after reset a clearing pass over all EVENTS (256) entries runs before
// the first item is taken; configuration writes are taken during it.
// The user must write latch_limit through cfg_we/cfg_wdata only while the
// block is idle; the block does not check this. When the receiver stalls,
// the result holds in the output register and no new item is taken until the
// result beat completes. Thread slots and run head/tail are flip-flops cleared
// by arst_n; mode and link memories are written before they are read.
`timescale 1ns / 1ps
`default_nettype none
module thread_event_wait_queue_engine_top
	import tewq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] kind,
	input  wire logic [5:0] thread_id,
	input  wire logic [7:0] event_id,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic      [2:0] status,
	output logic      [5:0] thread_out,
	output logic            woke,
	output logic            pending
);
	fsm_t state_q, state_d;
	logic [8:0] latch_q;
	logic [THREADS-1:0] used_q;
	logic run_empty_q;
	logic [TW-1:0] run_head_q, run_tail_q;
	logic [EW:0] clr_q;

	// captured item
	logic [2:0] kind_q;
	logic [TW-1:0] tid_q;
	logic [EW-1:0] ev_q;
	logic [TW-1:0] prev_q;
	logic [TW:0] cnt_q;
	logic found_q;
	logic [TW-1:0] fprev_q;

	// event memory
	logic ev_we;
	logic [EW-1:0] ev_waddr, ev_raddr;
	evq_t ev_wdata, ev_rdata;
	// run link and wait link memories
	logic rn_we, wn_we;
	logic [TW-1:0] rn_waddr, rn_wdata, rn_raddr, rn_rdata;
	logic [TW-1:0] wn_waddr, wn_wdata, wn_raddr, wn_rdata;
	// thread mode memory
	logic md_we;
	logic [TW-1:0] md_waddr, md_raddr;
	mode_t md_wdata;
	logic [1:0] md_rdata;
	mode_t md_mode;

	tewq_ram #(.DEPTH(EVENTS), .WIDTH($bits(evq_t))) u_ev (
		.clk, .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
		.raddr(ev_raddr), .rdata(ev_rdata)
	);
	tewq_ram #(.DEPTH(THREADS), .WIDTH(TW)) u_rn (
		.clk, .we(rn_we), .waddr(rn_waddr), .wdata(rn_wdata),
		.raddr(rn_raddr), .rdata(rn_rdata)
	);
	tewq_ram #(.DEPTH(THREADS), .WIDTH(TW)) u_wn (
		.clk, .we(wn_we), .waddr(wn_waddr), .wdata(wn_wdata),
		.raddr(wn_raddr), .rdata(wn_rdata)
	);
	tewq_ram #(.DEPTH(THREADS), .WIDTH(2)) u_md (
		.clk, .we(md_we), .waddr(md_waddr), .wdata(md_wdata),
		.raddr(md_raddr), .rdata(md_rdata)
	);

	// lowest free slot
	logic free_any;
	logic [TW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = TW'(i);
			end
		end
	end

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	logic tok;
	assign tok = used_q[tid_q];
	logic ev_pend;
	assign ev_pend = ev_rdata.pend;
	assign md_mode = mode_t'(md_rdata);

	// read addresses
	assign ev_raddr = ev_q;
	assign wn_raddr = ev_rdata.front;
	assign md_raddr = tid_q;
	// walk reads next of prev; before the walk read next of head
	assign rn_raddr = (state_q == S_WALK || state_q == S_WALKRD) ? prev_q : run_head_q;

	// next-state and memory write control
	logic res_ld;
	status_t res_st;
	logic [TW-1:0] res_t;
	logic res_w;
	always_comb begin
		state_d = state_q;
		ev_we = 1'b0; ev_waddr = clr_q[EW-1:0]; ev_wdata = '0;
		rn_we = 1'b0; rn_waddr = run_tail_q; rn_wdata = tid_q;
		wn_we = 1'b0; wn_waddr = ev_rdata.back; wn_wdata = tid_q;
		md_we = 1'b0; md_waddr = tid_q; md_wdata = M_PAUSED;
		res_ld = 1'b0; res_st = ST_OK; res_t = '0; res_w = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ev_we = 1'b1;
				if (clr_q == (EW+1)'(EVENTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: if (accept) state_d = S_READ;
			// a send also needs the wait link of the front waiter
			S_READ: state_d = (kind_t'(kind_q) == K_SEND) ? S_LINK : S_EXEC;
			S_LINK: state_d = S_EXEC;
			S_EXEC: begin
				res_ld = 1'b1;
				state_d = S_OUT;
				unique case (kind_t'(kind_q))
					K_NEW: begin
						if (free_any) begin
							res_t = free_idx;
							md_we = 1'b1; md_waddr = free_idx;
						end else res_st = ST_FULL;
					end
					K_WAIT: begin
						if (!tok) res_st = ST_NO_THREAD;
						else if (md_mode != M_PAUSED) res_st = ST_BUSY;
						else if (ev_pend) begin
							rn_we = !run_empty_q;
							md_we = 1'b1; md_wdata = M_QUEUED;
						end else begin
							wn_we = ev_rdata.valid;
							ev_we = 1'b1; ev_waddr = ev_q;
							ev_wdata = ev_rdata;
							ev_wdata.valid = 1'b1;
							ev_wdata.front = ev_rdata.valid ? ev_rdata.front : tid_q;
							ev_wdata.back = tid_q;
							md_we = 1'b1; md_wdata = M_WAITING;
						end
					end
					K_SEND: begin
						ev_we = 1'b1; ev_waddr = ev_q;
						ev_wdata = ev_rdata;
						if (ev_rdata.valid) begin
							res_t = ev_rdata.front; res_w = 1'b1;
							rn_we = !run_empty_q; rn_wdata = ev_rdata.front;
							ev_wdata.valid = (ev_rdata.back != ev_rdata.front);
							ev_wdata.front = wn_rdata;
							md_we = 1'b1; md_waddr = ev_rdata.front; md_wdata = M_QUEUED;
						end
						if ({1'b0, ev_q} < latch_q) ev_wdata.pend = 1'b1;
					end
					K_DEQ: begin
						if (!tok) res_st = ST_NO_THREAD;
						else if (run_empty_q) res_st = ST_EMPTY;
						else if (run_head_q != tid_q && run_head_q != run_tail_q) begin
							res_ld = 1'b0; state_d = S_WALK;
						end else if (run_head_q != tid_q) res_st = ST_BUSY;
						else md_we = 1'b1;
					end
					K_KILL: begin
						if (!tok) res_st = ST_NO_THREAD;
						else if (md_mode != M_PAUSED) res_st = ST_BUSY;
					end
					K_PEEK: begin
						if (run_empty_q) res_st = ST_EMPTY;
						else res_t = run_head_q;
					end
					K_CLEAR: begin
						ev_we = 1'b1; ev_waddr = ev_q;
						ev_wdata = ev_rdata;
						ev_wdata.pend = 1'b0;
					end
					default: ;
				endcase
			end
			S_WALK: begin
				// rn_rdata = next of prev, or next of the found thread when found
				if (found_q) begin
					rn_we = 1'b1; rn_waddr = fprev_q; rn_wdata = rn_rdata;
					res_ld = 1'b1; state_d = S_OUT;
				end else if (rn_rdata == tid_q) begin
					md_we = 1'b1;
					if (run_tail_q == tid_q) begin
						res_ld = 1'b1; state_d = S_OUT;
					end else state_d = S_WALKRD;
				end else if (rn_rdata == run_tail_q || cnt_q == (TW+1)'(THREADS)) begin
					res_ld = 1'b1; res_st = ST_BUSY; state_d = S_OUT;
				end else state_d = S_WALKRD;
			end
			// link read of the next member or of the found thread
			S_WALKRD: state_d = S_WALK;
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			latch_q <= LATCH_RESET;
			used_q <= '0;
			run_empty_q <= 1'b1;
			run_head_q <= '0;
			run_tail_q <= '0;
			out_valid <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) latch_q <= cfg_wdata;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_ld) out_valid <= 1'b1;
			else if (state_q == S_OUT && !out_stall) out_valid <= 1'b0;
			if (state_q == S_EXEC) begin
				found_q <= 1'b0;
				unique case (kind_t'(kind_q))
					K_NEW: if (free_any) used_q[free_idx] <= 1'b1;
					K_WAIT: if (tok && md_mode == M_PAUSED && ev_pend) begin
						if (run_empty_q) run_head_q <= tid_q;
						run_empty_q <= 1'b0;
						run_tail_q <= tid_q;
					end
					K_SEND: if (ev_rdata.valid) begin
						if (run_empty_q) run_head_q <= ev_rdata.front;
						run_empty_q <= 1'b0;
						run_tail_q <= ev_rdata.front;
					end
					K_DEQ: if (tok && !run_empty_q && run_head_q == tid_q) begin
						if (run_tail_q == tid_q) run_empty_q <= 1'b1;
						else run_head_q <= rn_rdata;
					end
					K_KILL: if (tok && md_mode == M_PAUSED) used_q[tid_q] <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == S_WALK) begin
				if (found_q) found_q <= 1'b0;
				else if (rn_rdata == tid_q) begin
					if (run_tail_q == tid_q) run_tail_q <= prev_q;
					else found_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			tid_q <= thread_id;
			ev_q <= event_id;
		end
		if (state_q == S_EXEC) begin
			prev_q <= run_head_q;
			cnt_q <= '0;
		end
		if (state_q == S_WALK && !found_q) begin
			if (rn_rdata == tid_q) begin
				fprev_q <= prev_q;
				prev_q <= tid_q;
			end else prev_q <= rn_rdata;
			cnt_q <= cnt_q + 1'b1;
		end
		if (res_ld) begin
			status <= res_st;
			thread_out <= res_t;
			woke <= res_w;
			pending <= (kind_t'(kind_q) == K_SEND && {1'b0, ev_q} < latch_q)
				? 1'b1 : ((kind_t'(kind_q) == K_CLEAR) ? 1'b0 : ev_pend);
		end
	end
endmodule
`default_nettype wire

FILE: dv/tewq_checker.sv
// Checker: watches both channels, predicts each result of the engine and compares.
`timescale 1ns / 1ps
`default_nettype none
module tewq_checker
	import tewq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [2:0] kind,
	input  wire logic [5:0] thread_id,
	input  wire logic [7:0] event_id,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [2:0] status,
	input  wire logic [5:0] thread_out,
	input  wire logic       woke,
	input  wire logic       pending,
	output int              fail_count,
	output int              expected_left,
	output int              results_seen,
	output int              wakes_seen
);
	typedef struct packed {
		status_t    st;
		logic [5:0] tout;
		logic       wk;
		logic       pnd;
	} sched_result_t;

	sched_result_t due_results[$];

	// shadow scheduler state
	logic       used_m [THREADS];
	mode_t      mode_m [THREADS];
	logic [5:0] run_link [THREADS];
	logic [5:0] wait_link [THREADS];
	logic [6:0] run_first;
	logic [5:0] run_last;
	evq_t       evq_m [EVENTS];
	logic       pend_m [EVENTS];
	logic [8:0] limit_m;

	function automatic void run_append(input logic [5:0] t);
		if (run_first >= THREADS) run_first = {1'b0, t};
		else run_link[run_last] = t;
		run_last = t;
		mode_m[t] = M_QUEUED;
	endfunction

	function automatic status_t run_unlink(input logic [5:0] t);
		logic [5:0] prev;
		logic [5:0] nx;
		if (run_first >= THREADS) return ST_EMPTY;
		if (run_first[5:0] == t) begin
			if (run_last == t) run_first = 7'(THREADS);
			else run_first = {1'b0, run_link[t]};
			return ST_OK;
		end
		prev = run_first[5:0];
		for (int i = 0; i < THREADS && prev != run_last; i++) begin
			nx = run_link[prev];
			if (nx == t) begin
				if (run_last == t) run_last = prev;
				else run_link[prev] = run_link[t];
				return ST_OK;
			end
			prev = nx;
		end
		return ST_BUSY;
	endfunction

	// predict one result and update shadow state
	function automatic sched_result_t schedule_step(input kind_t k, input logic [5:0] t,
			input logic [7:0] e);
		sched_result_t r;
		logic [5:0] w;
		r = '0;
		r.st = ST_OK;
		case (k)
			K_NEW: begin
				r.st = ST_FULL;
				for (int i = 0; i < THREADS; i++) begin
					if (!used_m[i]) begin
						used_m[i] = 1'b1;
						mode_m[i] = M_PAUSED;
						r.tout = 6'(i);
						r.st = ST_OK;
						break;
					end
				end
			end
			K_WAIT: begin
				if (!used_m[t]) r.st = ST_NO_THREAD;
				else if (mode_m[t] != M_PAUSED) r.st = ST_BUSY;
				else if (pend_m[e]) run_append(t);
				else begin
					if (evq_m[e].valid) wait_link[evq_m[e].back] = t;
					else evq_m[e].front = t;
					evq_m[e].back = t;
					evq_m[e].valid = 1'b1;
					mode_m[t] = M_WAITING;
				end
			end
			K_SEND: begin
				if (evq_m[e].valid) begin
					w = evq_m[e].front;
					if (evq_m[e].back == w) evq_m[e].valid = 1'b0;
					else evq_m[e].front = wait_link[w];
					run_append(w);
					r.tout = w;
					r.wk = 1'b1;
				end
				if ({1'b0, e} < limit_m) pend_m[e] = 1'b1;
			end
			K_DEQ: begin
				if (!used_m[t]) r.st = ST_NO_THREAD;
				else begin
					r.st = run_unlink(t);
					if (r.st == ST_OK) mode_m[t] = M_PAUSED;
				end
			end
			K_KILL: begin
				if (!used_m[t]) r.st = ST_NO_THREAD;
				else if (mode_m[t] != M_PAUSED) r.st = ST_BUSY;
				else used_m[t] = 1'b0;
			end
			K_PEEK: begin
				if (run_first >= THREADS) r.st = ST_EMPTY;
				else r.tout = run_first[5:0];
			end
			K_POLL: ;
			default: pend_m[e] = 1'b0;
		endcase
		r.pnd = pend_m[e];
		return r;
	endfunction

	// reset shadow state, then follow config writes and input beats
	always @(posedge clk or negedge arst_n) begin
		sched_result_t got;
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				used_m[i] = 1'b0;
				mode_m[i] = M_PAUSED;
				run_link[i] = '0;
				wait_link[i] = '0;
			end
			for (int i = 0; i < EVENTS; i++) begin
				evq_m[i] = '0;
				pend_m[i] = 1'b0;
			end
			run_first = 7'(THREADS);
			run_last = '0;
			limit_m = LATCH_RESET;
			due_results.delete();
			expected_left = 0;
			fail_count = 0;
			results_seen = 0;
			wakes_seen = 0;
		end else begin
			if (cfg_we) limit_m = cfg_wdata;
			if (in_valid && !in_stall)
				due_results.push_back(schedule_step(kind_t'(kind), thread_id, event_id));
			if (out_valid && !out_stall) begin
				got = {status_t'(status), thread_out, woke, pending};
				results_seen++;
				if (woke) wakes_seen++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected: %p", $realtime, got);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp st=%0d t=%0d w=%0d p=%0d got st=%0d t=%0d w=%0d p=%0d",
								$realtime, want.st, want.tout, want.wk, want.pnd,
								status, thread_out, woke, pending);
					end
				end
			end
			expected_left = due_results.size();
		end
	end
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench top: drives stimulus into the engine and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import tewq_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] kind;
	logic [5:0] thread_id;
	logic [7:0] event_id;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] status;
	logic [5:0] thread_out;
	logic       woke;
	logic       pending;
	int         fail_count;
	int         expected_left;
	int         results_seen;
	int         wakes_seen;
	int         idle_cycles;
	int         stall_mode;

	localparam int WATCHDOG = 5000;

	thread_event_wait_queue_engine_top DUT (.*);

	tewq_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stall pattern: switches between none, light and heavy stalling
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("FAIL");
			$finish;
		end
	end

	int gap_left;
	int burst_left;

	// send one beat; valid stays high within a burst, gaps drop it
	task automatic send_op(input kind_t k, input logic [5:0] t, input logic [7:0] e);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		thread_id <= t;
		event_id <= e;
		do @(posedge clk); while (in_stall);
	endtask

	// wait until every expected result is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_left != 0) @(posedge clk);
		repeat (2 * THREADS + 10) @(posedge clk);
	endtask

	task automatic set_limit(input logic [8:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random traffic: events mostly from a small pool so waits and sends meet
	task automatic random_phase(input int n);
		kind_t k;
		logic [7:0] e;
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 3) k = K_NEW;
			e = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
			if ($urandom_range(0, 7) == 0) e = 8'(239 + $urandom_range(0, 2));
			send_op(k, ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 9)), e);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = '0;
		thread_id = '0;
		event_id = '0;
		out_stall = 1'b0;
		stall_mode = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue cases, unknown threads, edge events
		send_op(K_PEEK, 6'd0, 8'd0);
		send_op(K_DEQ, 6'd63, 8'd0);
		send_op(K_KILL, 6'd5, 8'd0);
		send_op(K_WAIT, 6'd0, 8'd255);
		send_op(K_NEW, 6'd63, 8'd255);
		send_op(K_NEW, 6'd0, 8'd0);
		send_op(K_NEW, 6'd0, 8'd0);
		send_op(K_DEQ, 6'd0, 8'd0);
		send_op(K_WAIT, 6'd0, 8'd255);
		send_op(K_WAIT, 6'd1, 8'd255);
		send_op(K_WAIT, 6'd1, 8'd3);
		send_op(K_KILL, 6'd0, 8'd0);
		send_op(K_SEND, 6'd0, 8'd255);
		send_op(K_SEND, 6'd0, 8'd239);
		send_op(K_POLL, 6'd0, 8'd239);
		send_op(K_WAIT, 6'd2, 8'd239);
		send_op(K_PEEK, 6'd0, 8'd0);
		send_op(K_DEQ, 6'd1, 8'd0);
		send_op(K_DEQ, 6'd0, 8'd0);
		send_op(K_CLEAR, 6'd0, 8'd239);
		send_op(K_POLL, 6'd0, 8'd240);
		send_op(K_SEND, 6'd0, 8'd240);

		// fill the table past full, then random traffic under several limits
		for (int i = 0; i < 66; i++) send_op(K_NEW, 6'd0, 8'd0);
		random_phase(70);
		set_limit(9'd0);
		random_phase(70);
		set_limit(9'd256);
		for (int i = 0; i < 64; i++) send_op(K_KILL, 6'(i), 8'd0);
		random_phase(70);
		set_limit(9'd3);
		random_phase(70);
		drain();

		$display("Ran about 430 operations of all kinds under latch limits 240, 0, 256 and 3;");
		$display("%0d results checked, %0d of them sends that woke a waiter.",
			results_seen, wakes_seen);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: thread_event_wait_queue_engine_top.f
rtl/tewq_pkg.sv
rtl/tewq_ram.sv
rtl/thread_event_wait_queue_engine_top.sv
dv/tewq_checker.sv
dv/tb.sv
